### src/assert_macros.svh
// Assertion macros shared by the PCM to PWM word generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/spwm_pkg.sv
// Types, constants and helper functions of the PCM to PWM word generator.
package spwm_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned ERR_W   = 11;
  localparam int unsigned SUM_W   = LEVEL_W + 1;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BPS_W   = 4;
  localparam int unsigned SHIFT_W = 3;

  localparam logic [BPS_W-1:0] BPS_MIN   = 4'd5;
  localparam logic [BPS_W-1:0] BPS_MAX   = 4'd11;
  localparam logic [BPS_W-1:0] BPS_RESET = 4'd9;

  // One input item: a stereo sample pair.
  typedef struct packed {
    logic signed [LEVEL_W-1:0] left_sample;
    logic signed [LEVEL_W-1:0] right_sample;
  } in_item_t;

  // One result item: a pair of thermometer words.
  typedef struct packed {
    logic [WORD_W-1:0] left_pwm_word;
    logic [WORD_W-1:0] right_pwm_word;
    logic              last_word;
  } out_item_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
    logic [CNT_W-1:0]   last_index;
  } job_t;

  // Thermometer word with count ones packed from the MSB; count is 0..32.
  function automatic logic [WORD_W-1:0] therm_word(input logic [CNT_W-1:0] count);
    logic [WORD_W-1:0] word;
    if (count[CNT_W-1]) begin
      word = '1;
    end else begin
      word = ~({WORD_W{1'b1}} >> count[CNT_W-2:0]);
    end
    return word;
  endfunction

endpackage

### src/spwm_front.sv
// Front end: holds the word count setting and classifies incoming sample pairs.
module spwm_front import spwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [BPS_W-1:0] cfg_data,
  input  in_item_t         in_data,
  output job_t             job
);

  logic [BPS_W-1:0]   bits_per_sample;
  logic [BPS_W-1:0]   bps_sat;
  logic [SHIFT_W-1:0] shift;
  logic [CNT_W:0]     words;

  // The setting register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_sample <= BPS_RESET;
    end else if (cfg_valid) begin
      bits_per_sample <= cfg_data;
    end
  end

  // Clamp the setting to its legal range and derive the word count.
  always_comb begin
    if (bits_per_sample < BPS_MIN) begin
      bps_sat = BPS_MIN;
    end else if (bits_per_sample > BPS_MAX) begin
      bps_sat = BPS_MAX;
    end else begin
      bps_sat = bits_per_sample;
    end
    shift = SHIFT_W'(bps_sat - BPS_MIN);
    words = (CNT_W+1)'(1) << shift;
  end

  // Offsetting by half scale flips the sign bit; the last word index is one less than the word count.
  always_comb begin
    job.left_level  = {~in_data.left_sample[LEVEL_W-1], in_data.left_sample[LEVEL_W-2:0]};
    job.right_level = {~in_data.right_sample[LEVEL_W-1], in_data.right_sample[LEVEL_W-2:0]};
    job.last_index  = CNT_W'(words - (CNT_W+1)'(1));
  end

endmodule

### src/spwm_queue.sv
// Short first-in first-out queue between the front end and the word generator.
`include "assert_macros.svh"
module spwm_queue import spwm_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full       = (fill == FILL_MAX);
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  `ASSERT_RST(a_fill_bound, fill <= FILL_MAX, "queue fill level above depth")
  `ASSERT_RST(a_pop_nonempty, pop |-> head_valid, "pop from an empty queue")

endmodule

### src/spwm_back.sv
// Back end: emits the PWM word pairs of the head item with error feedback.
`include "assert_macros.svh"
module spwm_back import spwm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [ERR_W-1:0] left_error;
  logic [ERR_W-1:0] right_error;
  logic [CNT_W-1:0] word_counter;
  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] right_sum;
  logic             advance;
  logic             last;

  // A word is produced whenever an item waits and the output slot is free.
  assign advance = head_valid && (!out_valid || out_ready);
  assign last    = (word_counter == head.last_index);
  assign pop     = advance && last;

  // Level plus carried remainder for both channels.
  assign left_sum  = {1'b0, head.left_level} + SUM_W'(left_error);
  assign right_sum = {1'b0, head.right_level} + SUM_W'(right_error);

  // Remainders and word index.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_error   <= '0;
      right_error  <= '0;
      word_counter <= '0;
    end else if (advance) begin
      left_error   <= left_sum[ERR_W-1:0];
      right_error  <= right_sum[ERR_W-1:0];
      word_counter <= last ? '0 : word_counter + CNT_W'(1);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.left_pwm_word  <= therm_word(left_sum[SUM_W-1:ERR_W]);
      out_data.right_pwm_word <= therm_word(right_sum[SUM_W-1:ERR_W]);
      out_data.last_word      <= last;
    end
  end

  `ASSERT_RST(a_counter_bound, head_valid |-> word_counter <= head.last_index,
              "word index past the last word of the item")
  `ASSERT_RST(a_counter_idle, !head_valid |-> word_counter == '0,
              "word index not at zero between items")
  `ASSERT_RST(a_last_pops, (advance && last) |=> (out_valid && out_data.last_word),
              "final word of an item not flagged")

endmodule

### src/stereo_pcm_to_pwm_words_top.sv
// Top level of the stereo PCM to thermometer PWM word generator.
//
// Usage:
//   in_valid/in_ready/in_data carry one stereo sample pair per item.
//   out_valid/out_ready/out_data carry one left/right PWM word pair per item;
//   out_data.last_word marks the final word pair of a sample pair.
//   cfg_valid/cfg_ready/cfg_data write bits_per_sample (cfg_ready is always
//   high); write it only while no sample pair is in flight.
// Throughput: a sample pair yields 2^(bits_per_sample-5) word pairs, setting
//   clamped to 5..11, one word pair per cycle while out_ready is high, from
//   the single error-feedback datapath; the default of 9 gives 16 word pairs.
// Path: a sample pair taken in waits in a queue slot; its word pairs leave
//   through the output register. The queue holds QUEUE_DEPTH sample pairs,
//   so new input is taken while the current one is still being expanded.
// Reset: clears the remainders, the queue and the output valid flag, and sets
//   bits_per_sample to 9.
// Stall: with out_ready low the output word holds; the queue fills and then
//   in_ready drops.
module stereo_pcm_to_pwm_words_top import spwm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [BPS_W-1:0] cfg_data
);

  job_t job;
  job_t head;
  logic full;
  logic head_valid;
  logic pop;

  assign in_ready = !full;

  // Setting register and item classification.
  spwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .job       (job)
  );

  // Queue between front and back.
  spwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_data  (job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Word generator with output register.
  spwm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### tb/sv/stereo_pcm_to_pwm_words_top_tb.sv
// Self-checking testbench of the stereo PCM to thermometer PWM word generator.
`timescale 1ns / 100ps

module stereo_pcm_to_pwm_words_top_tb import spwm_pkg::*;;

  localparam int unsigned RANDOM_PAIRS = 110;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 16;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_SLUGGISH
  } rx_mode_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [BPS_W-1:0] cfg_data  = '0;

  // Predictor state: the register copy and both channel remainders.
  logic [BPS_W-1:0] bps_setting = BPS_RESET;
  logic [10:0]      left_rem    = '0;
  logic [10:0]      right_rem   = '0;
  out_item_t        pwm_expect_q[$];

  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_left     = 0;
  rx_mode_t    rx_mode     = RX_STEADY;

  stereo_pcm_to_pwm_words_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // One error-feedback step: the top bits of level plus remainder give the
  // number of leading ones, the low bits are carried to the next word.
  function automatic logic [31:0] feedback_word(input logic [15:0] level,
                                                inout logic [10:0] rem);
    logic [16:0] total;
    logic [5:0]  ones;
    total = {1'b0, level} + {6'b0, rem};
    ones  = total[16:11];
    rem   = total[10:0];
    if (ones >= 6'd32) begin
      return '1;
    end
    return ~(32'hFFFF_FFFF >> ones);
  endfunction

  // Expand one accepted sample pair into its expected word pairs.
  task automatic predict_words(input in_item_t pair);
    logic [BPS_W-1:0] eff_bps;
    logic [15:0]      left_level;
    logic [15:0]      right_level;
    int unsigned      words;
    out_item_t        word_pair;
    eff_bps = bps_setting;
    if (eff_bps < BPS_MIN) begin
      eff_bps = BPS_MIN;
    end
    if (eff_bps > BPS_MAX) begin
      eff_bps = BPS_MAX;
    end
    words       = 1 << (eff_bps - BPS_MIN);
    left_level  = pair.left_sample ^ 16'h8000;
    right_level = pair.right_sample ^ 16'h8000;
    for (int unsigned w = 0; w < words; w++) begin
      word_pair.left_pwm_word  = feedback_word(left_level, left_rem);
      word_pair.right_pwm_word = feedback_word(right_level, right_rem);
      word_pair.last_word      = (w == words - 1);
      pwm_expect_q.push_back(word_pair);
    end
  endtask

  // Send one sample pair; bursts of random length are sometimes separated by gaps.
  task automatic send_pair(input logic [15:0] left, input logic [15:0] right);
    int unsigned gap;
    in_item_t    pair;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pair.left_sample  = left;
    pair.right_sample = right;
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk); while (!in_ready);
    predict_words(pair);
  endtask

  // Stop sending and wait until every expected word pair has come out.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pwm_expect_q.size() != 0) @(posedge clk);
  endtask

  // Write bits_per_sample while nothing is in flight.
  task automatic write_bps(input logic [BPS_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    bps_setting = value;
    cfg_valid <= 1'b0;
  endtask

  // Sample with extra weight on the full-scale ends and on values near zero.
  function automatic logic [15:0] pick_sample;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return 16'h8000;
    end else if (sel == 1) begin
      return 16'h7FFF;
    end else if (sel == 2) begin
      return 16'($signed($urandom_range(0, 64)) - 32);
    end
    return 16'($urandom);
  endfunction

  // The default setting: full-scale, zero and boundary samples.
  task automatic test_default_setting;
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'h7800, 16'h77FF);
    send_pair(16'h8001, 16'h8800);
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h5555, 16'hAAAA);
  endtask

  // Settings below, at and above the supported range.
  task automatic test_setting_extremes;
    logic [BPS_W-1:0] settings[6] = '{4'd0, 4'd4, 4'd5, 4'd12, 4'd15, 4'd11};
    foreach (settings[i]) begin
      write_bps(settings[i]);
      send_pair(16'h7FFF, 16'h8000);
      send_pair(pick_sample(), pick_sample());
    end
  endtask

  // Random phases, mostly with short word counts, a few with long ones up to the longest.
  task automatic test_random_pairs;
    int unsigned sent;
    int unsigned n;
    int unsigned sel;
    logic [BPS_W-1:0] setting;
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        setting = BPS_W'($urandom_range(5, 8));
      end else if (sel < 8) begin
        setting = BPS_W'($urandom_range(0, 4));
      end else begin
        setting = BPS_W'($urandom_range(9, 15));
      end
      write_bps(setting);
      n = (setting > 4'd9) ? $urandom_range(1, 4) : $urandom_range(6, 20);
      repeat (n) send_pair(pick_sample(), pick_sample());
      sent += n;
    end
  endtask

  // Receiver stall pattern: steady, choppy or sluggish stretches.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_STEADY: begin
        out_ready <= 1'b1;
      end
      RX_CHOPPY: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_ready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  // Compare each accepted word pair with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pwm_expect_q.size() == 0) begin
        $error("unexpected word pair: left %h right %h last %b",
               out_data.left_pwm_word, out_data.right_pwm_word, out_data.last_word);
        error_count++;
      end else begin
        want = pwm_expect_q.pop_front();
        if (out_data.left_pwm_word !== want.left_pwm_word) begin
          $error("left_pwm_word: expected %h, actual %h",
                 want.left_pwm_word, out_data.left_pwm_word);
          error_count++;
        end
        if (out_data.right_pwm_word !== want.right_pwm_word) begin
          $error("right_pwm_word: expected %h, actual %h",
                 want.right_pwm_word, out_data.right_pwm_word);
          error_count++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word: expected %b, actual %b", want.last_word, out_data.last_word);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stereo_pcm_to_pwm_words_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_setting();
    test_setting_extremes();
    test_random_pairs();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("stereo_pcm_to_pwm_words_top_tb: PASS");
    end else begin
      $display("stereo_pcm_to_pwm_words_top_tb: FAIL");
    end
    $finish;
  end

endmodule
